### hw/rtl/vrsp_pkg.sv
`default_nettype none

package vrsp_pkg;

  localparam logic [7:0]  CharNul    = 8'h00;
  localparam logic [7:0]  CharZero   = 8'h30;
  localparam logic [7:0]  CharNine   = 8'h39;
  localparam logic [7:0]  CharX      = 8'h78;
  localparam logic [7:0]  CharP      = 8'h70;
  localparam logic [15:0] DefWidth   = 16'd640;
  localparam logic [15:0] DefHeight  = 16'd480;
  localparam logic [15:0] AccMax     = 16'hFFFF;

  typedef enum logic [3:0] {
    PhWidth  = 4'b0001,
    PhHeight = 4'b0010,
    PhRate   = 4'b0100,
    PhError  = 4'b1000
  } phase_e;

  // Character held in the input register.
  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
  } char_stage_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] fps;
    logic        error;
  } result_t;

  // Result handed from the parser to the output register.
  typedef struct packed {
    logic    emit;
    result_t res;
  } emit_t;

  // acc * 10 + digit, held at the maximum instead of wrapping.
  function automatic logic [15:0] accumulate(logic [15:0] acc, logic [3:0] digit);
    logic [19:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, digit};
    return (sum > {4'h0, AccMax}) ? AccMax : sum[15:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vrsp_char_if.sv
`default_nettype none

interface vrsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

### hw/rtl/vrsp_result_if.sv
`default_nettype none

interface vrsp_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] fps;
  logic        error;

  modport source (output valid, output width, output height, output fps, output error,
                  input ready);
  modport sink   (input valid, input width, input height, input fps, input error,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/video_resolution_string_parser_unit.sv
`default_nettype none

// Resolution text parser. Feed one character of "WIDTHxHEIGHT" or
// "WIDTHxHEIGHTpFPS" per transaction on char_i, ending with a zero byte; each
// zero byte produces one transaction on result_o with width, height and fps
// (fps 0 when absent), or 640, 480, 0 with error set when the text is
// malformed. Values saturate at 65535 and an empty digit run reads as 0. The
// block takes one character per cycle unless a zero byte waits in the input
// register. Each character is held in the input register, then the parser
// updates its accumulators with a multiply-by-ten and add. The result register
// loads at the clock edge at which the zero byte leaves the input register, so
// result_o.valid rises in the cycle after that. A zero byte waits there only
// while the result register holds an untaken result; other characters never do.
module video_resolution_string_parser_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  vrsp_char_if.sink         char_i,
  vrsp_result_if.source     result_o
);

  vrsp_pkg::char_stage_t stage;
  vrsp_pkg::emit_t       emit;
  vrsp_pkg::result_t     res;
  logic                  out_free;
  logic                  adv;

  // Only a terminator needs a free result slot to move on.
  assign adv = stage.vld && ((stage.ch != vrsp_pkg::CharNul) || out_free);

  vrsp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ch_i    (char_i.ch),
    .in_ready_o (char_i.ready),
    .adv_i      (adv),
    .stage_o    (stage)
  );

  vrsp_parse_core u_parse_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .stage_i (stage),
    .emit_o  (emit)
  );

  vrsp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_res_o   (res),
    .free_o      (out_free)
  );

  assign result_o.width  = res.width;
  assign result_o.height = res.height;
  assign result_o.fps    = res.fps;
  assign result_o.error  = res.error;

  a_term_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage.vld && (stage.ch == vrsp_pkg::CharNul) && out_free) |=> result_o.valid)
    else $error("terminator did not produce a result");

  a_error_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.error) |->
      ((result_o.width == vrsp_pkg::DefWidth) && (result_o.height == vrsp_pkg::DefHeight)
       && (result_o.fps == 16'h0000)))
    else $error("error result without default values");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage.vld && !adv) |=> (stage.vld && $stable(stage.ch)))
    else $error("stalled character lost from input register");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> out_free)
    else $error("result emitted into an occupied output register");

endmodule

`default_nettype wire

### hw/rtl/vrsp_in_stage.sv
`default_nettype none

module vrsp_in_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [7:0]           in_ch_i,
  output logic                      in_ready_o,
  input  wire logic                 adv_i,
  output vrsp_pkg::char_stage_t     stage_o
);

  logic       vld_q, vld_d;
  logic [7:0] ch_q;

  assign in_ready_o = !vld_q || adv_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Load a new character whenever the register is free or drains.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q <= in_ch_i;
    end
  end

  assign stage_o.vld = vld_q;
  assign stage_o.ch  = ch_q;

endmodule

`default_nettype wire

### hw/rtl/vrsp_parse_core.sv
`default_nettype none

module vrsp_parse_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire vrsp_pkg::char_stage_t stage_i,
  output vrsp_pkg::emit_t            emit_o
);

  vrsp_pkg::phase_e phase_q, phase_d;
  logic [15:0]      width_q, width_d;
  logic [15:0]      height_q, height_d;
  logic [15:0]      rate_q, rate_d;
  logic [3:0]       digit;
  logic             is_digit;

  // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value.
  assign digit    = stage_i.ch[3:0];
  assign is_digit = (stage_i.ch >= vrsp_pkg::CharZero) && (stage_i.ch <= vrsp_pkg::CharNine);

  always_comb begin
    phase_d  = phase_q;
    width_d  = width_q;
    height_d = height_q;
    rate_d   = rate_q;
    emit_o   = '0;

    emit_o.res.width  = width_q;
    emit_o.res.height = height_q;
    emit_o.res.fps    = (phase_q == vrsp_pkg::PhRate) ? rate_q : 16'h0000;
    emit_o.res.error  = (phase_q == vrsp_pkg::PhWidth) || (phase_q == vrsp_pkg::PhError);
    if (emit_o.res.error) begin
      emit_o.res.width  = vrsp_pkg::DefWidth;
      emit_o.res.height = vrsp_pkg::DefHeight;
      emit_o.res.fps    = 16'h0000;
    end

    if (adv_i) begin
      if (stage_i.ch == vrsp_pkg::CharNul) begin
        // Terminator: emit and return to the reset state.
        emit_o.emit = 1'b1;
        phase_d     = vrsp_pkg::PhWidth;
        width_d     = 16'h0000;
        height_d    = 16'h0000;
        rate_d      = 16'h0000;
      end else begin
        unique case (phase_q)
          vrsp_pkg::PhWidth: begin
            if (is_digit) begin
              width_d = vrsp_pkg::accumulate(width_q, digit);
            end else if (stage_i.ch == vrsp_pkg::CharX) begin
              phase_d = vrsp_pkg::PhHeight;
            end else begin
              phase_d = vrsp_pkg::PhError;
            end
          end
          vrsp_pkg::PhHeight: begin
            if (is_digit) begin
              height_d = vrsp_pkg::accumulate(height_q, digit);
            end else if (stage_i.ch == vrsp_pkg::CharP) begin
              phase_d = vrsp_pkg::PhRate;
            end else begin
              phase_d = vrsp_pkg::PhError;
            end
          end
          vrsp_pkg::PhRate: begin
            if (is_digit) begin
              rate_d = vrsp_pkg::accumulate(rate_q, digit);
            end else begin
              phase_d = vrsp_pkg::PhError;
            end
          end
          vrsp_pkg::PhError: begin
            phase_d = vrsp_pkg::PhError;
          end
          default: begin
            phase_d = vrsp_pkg::PhError;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= vrsp_pkg::PhWidth;
      width_q  <= 16'h0000;
      height_q <= 16'h0000;
      rate_q   <= 16'h0000;
    end else begin
      phase_q  <= phase_d;
      width_q  <= width_d;
      height_q <= height_d;
      rate_q   <= rate_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vrsp_out_stage.sv
`default_nettype none

module vrsp_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vrsp_pkg::emit_t  emit_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output vrsp_pkg::result_t     out_res_o,
  output logic                  free_o
);

  logic              vld_q, vld_d;
  vrsp_pkg::result_t res_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (emit_i.emit) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.emit) begin
      res_q <= emit_i.res;
    end
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

### verif/video_resolution_string_parser_unit_test.sv
`timescale 1ns / 100ps

module video_resolution_string_parser_unit_test;

  // Expected results of the parser, predicted one character at a time.
  class resolution_board;
    vrsp_pkg::result_t expected_q[$];
    vrsp_pkg::phase_e  ph;
    logic [15:0]       w_acc;
    logic [15:0]       h_acc;
    logic [15:0]       r_acc;
    int                fail_cnt;

    function new();
      clear();
      fail_cnt = 0;
    endfunction

    function void clear();
      ph    = vrsp_pkg::PhWidth;
      w_acc = '0;
      h_acc = '0;
      r_acc = '0;
    endfunction

    static function logic [15:0] mac10(logic [15:0] acc, logic [3:0] d);
      int unsigned v;
      v = 32'(acc) * 10 + 32'(d);
      return (v > 32'(vrsp_pkg::AccMax)) ? vrsp_pkg::AccMax : v[15:0];
    endfunction

    function void note_char(logic [7:0] c);
      vrsp_pkg::result_t r;
      if (c == vrsp_pkg::CharNul) begin
        if (ph == vrsp_pkg::PhWidth || ph == vrsp_pkg::PhError) begin
          r.width  = vrsp_pkg::DefWidth;
          r.height = vrsp_pkg::DefHeight;
          r.fps    = '0;
          r.error  = 1'b1;
        end else begin
          r.width  = w_acc;
          r.height = h_acc;
          r.fps    = (ph == vrsp_pkg::PhRate) ? r_acc : '0;
          r.error  = 1'b0;
        end
        expected_q.push_back(r);
        clear();
        return;
      end
      // Error phase swallows everything up to the terminator.
      if (ph == vrsp_pkg::PhError) return;
      if (c >= vrsp_pkg::CharZero && c <= vrsp_pkg::CharNine) begin
        case (ph)
          vrsp_pkg::PhWidth:  w_acc = mac10(w_acc, c[3:0]);
          vrsp_pkg::PhHeight: h_acc = mac10(h_acc, c[3:0]);
          default:            r_acc = mac10(r_acc, c[3:0]);
        endcase
      end else if (c == vrsp_pkg::CharX && ph == vrsp_pkg::PhWidth) begin
        ph = vrsp_pkg::PhHeight;
      end else if (c == vrsp_pkg::CharP && ph == vrsp_pkg::PhHeight) begin
        ph = vrsp_pkg::PhRate;
      end else begin
        ph = vrsp_pkg::PhError;
      end
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, actual %0d", name, exp, act);
        fail_cnt++;
      end
    endfunction

    function void check_result(logic [15:0] width, logic [15:0] height,
                               logic [15:0] fps, logic error);
      vrsp_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with none pending: width %0d height %0d fps %0d error %0d",
               width, height, fps, error);
        fail_cnt++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("width", exp.width, width);
      compare_field("height", exp.height, height);
      compare_field("fps", exp.fps, fps);
      compare_field("error", exp.error, error);
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        $error("%0d results never arrived", expected_q.size());
        fail_cnt++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vrsp_char_if   char_bus ();
  vrsp_result_if res_bus ();

  video_resolution_string_parser_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_bus),
    .result_o (res_bus)
  );

  resolution_board sb = new();

  logic [7:0] text_q[$];
  bit         send_idle;
  bit         stall_en;
  bit         long_hold_req;
  int         sent_cnt;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      sb.check_result(res_bus.width, res_bus.height, res_bus.fps, res_bus.error);
    end
  end

  initial begin : ready_drive
    int hold_left;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 300;
      end else if (hold_left == 0 && stall_en && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 5);
      end
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_bus.valid <= 1'b1;
    char_bus.ch    <= c;
    do @(posedge clk_i); while (!char_bus.ready);
    sb.note_char(c);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic flush_text();
    foreach (text_q[i]) send_char(text_q[i]);
    text_q.delete();
  endtask

  function void add_word(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function string rand_number();
    case ($urandom_range(0, 5))
      0:       return "";
      1:       return $sformatf("%0d", $urandom_range(0, 9));
      2:       return $sformatf("%0d", $urandom_range(0, 999));
      3:       return $sformatf("%0d", $urandom_range(0, 65535));
      4:       return $sformatf("%0d", $urandom_range(65500, 65600));
      default: return $sformatf("%0d", $urandom_range(60000, 999999));
    endcase
  endfunction

  function void build_random_text();
    int kind;
    int n;
    int pos;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      add_word(rand_number());
      text_q.push_back(vrsp_pkg::CharX);
      add_word(rand_number());
      if ($urandom_range(0, 1) == 1) begin
        text_q.push_back(vrsp_pkg::CharP);
        add_word(rand_number());
      end
      // Corrupt the text with one stray byte.
      if (kind == 1) begin
        pos = $urandom_range(0, text_q.size());
        text_q.insert(pos, 8'($urandom_range(0, 255)));
      end
    end
    text_q.push_back(vrsp_pkg::CharNul);
  endfunction

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    bit hold_done;
    int wait_cnt;
    hold_done      = 1'b0;
    char_bus.valid = 1'b0;
    char_bus.ch    = '0;
    send_idle      = 1'b1;
    stall_en       = 1'b1;
    long_hold_req  = 1'b0;
    sent_cnt       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Terminator while reading width.
    text_q.push_back(vrsp_pkg::CharNul);
    // Saturated width, empty rate after p.
    add_word("99999x1p");
    text_q.push_back(vrsp_pkg::CharNul);
    // Empty width and height, terminator while reading height.
    add_word("x");
    text_q.push_back(vrsp_pkg::CharNul);
    // p while reading width.
    add_word("p");
    text_q.push_back(vrsp_pkg::CharNul);
    // x while reading rate, then characters ignored in the error phase.
    add_word("xp1x9");
    text_q.push_back(vrsp_pkg::CharNul);
    // p while reading rate.
    add_word("xpp");
    text_q.push_back(vrsp_pkg::CharNul);
    // x while reading height.
    add_word("xx");
    text_q.push_back(vrsp_pkg::CharNul);
    // Other non-digit character.
    text_q.push_back(8'hFF);
    text_q.push_back(vrsp_pkg::CharNul);
    flush_text();

    while (sent_cnt < 1440) begin
      if (!hold_done && sent_cnt >= 600) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (sent_cnt >= 1250) begin
        send_idle = 1'b0;
        stall_en  = 1'b0;
      end else begin
        send_idle = ($urandom_range(0, 3) != 0);
        stall_en  = ($urandom_range(0, 3) != 0);
      end
      build_random_text();
      flush_text();
    end
    char_bus.valid <= 1'b0;

    wait_cnt = 0;
    while (sb.expected_q.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    sb.report_leftover();

    if (sb.fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### video_resolution_string_parser_unit.f
hw/rtl/vrsp_pkg.sv
hw/rtl/vrsp_char_if.sv
hw/rtl/vrsp_result_if.sv
hw/rtl/vrsp_in_stage.sv
hw/rtl/vrsp_parse_core.sv
hw/rtl/vrsp_out_stage.sv
hw/rtl/video_resolution_string_parser_unit.sv
verif/video_resolution_string_parser_unit_test.sv
